>>> rtl/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [15:0] UNIT_HI_BASE   = 16'hD800;
    localparam logic [15:0] UNIT_LO_BASE   = 16'hDC00;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [15:0] utf16_unit;
        logic        unit_valid;
        logic        string_end;
        logic        run_last;
    } t_out_word;

    // decoded event passed from front to back
    typedef struct packed {
        logic [20:0] code_point;
        logic        marker;
        logic        str_end;
    } t_evt;

endpackage

`default_nettype wire

>>> rtl/u8u16_front.sv
`default_nettype none

module u8u16_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire                    i_space,
    input  u8u16_pkg::t_in_word    i_in,
    output logic                   o_ready,
    output logic                   o_push,
    output u8u16_pkg::t_evt        o_evt
);
    import u8u16_pkg::*;

    logic [20:0] r_accum, n_accum;
    logic [1:0]  r_left, n_left;
    logic        r_bad, n_bad;
    logic        have_cp;
    logic [20:0] cp;
    logic [7:0]  b;
    logic        accept;

    assign b       = i_in.byte_value;
    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        n_accum = r_accum;
        n_left  = r_left;
        n_bad   = r_bad;
        have_cp = 1'b0;
        cp      = '0;
        if (r_left == 2'd0) begin
            if (b inside {[8'h00:8'h7F]}) begin
                cp      = {13'd0, b};
                have_cp = 1'b1;
            end else if (b inside {[8'hC0:8'hDF]}) begin
                n_accum = {16'd0, b[4:0]};
                n_left  = 2'd1;
                n_bad   = 1'b0;
            end else if (b inside {[8'hE0:8'hEF]}) begin
                n_accum = {17'd0, b[3:0]};
                n_left  = 2'd2;
                n_bad   = 1'b0;
            end else if (b inside {[8'hF0:8'hF7]}) begin
                n_accum = {18'd0, b[2:0]};
                n_left  = 2'd3;
                n_bad   = 1'b0;
            end else begin
                cp      = CP_REPLACEMENT;
                have_cp = 1'b1;
            end
        end else begin
            if (!r_bad) begin
                if (b[7:6] != 2'b10) begin
                    n_bad = 1'b1;
                end else begin
                    n_accum = {r_accum[14:0], b[5:0]};
                end
            end
            n_left = r_left - 2'd1;
            if (n_left == 2'd0) begin
                cp      = n_bad ? CP_REPLACEMENT : n_accum;
                have_cp = 1'b1;
                n_bad   = 1'b0;
                n_accum = '0;
            end
        end
    end

    assign o_push           = accept && (have_cp || i_in.last_byte);
    assign o_evt.code_point = cp;
    assign o_evt.marker     = !have_cp;
    assign o_evt.str_end    = i_in.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_left  <= '0;
            r_bad   <= 1'b0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_accum <= '0;
                r_left  <= '0;
                r_bad   <= 1'b0;
            end else begin
                r_accum <= n_accum;
                r_left  <= n_left;
                r_bad   <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/u8u16_fifo.sv
`default_nettype none

module u8u16_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  u8u16_pkg::t_evt     i_evt,
    input  wire                 i_pop,
    output logic                o_space,
    output logic                o_head_valid,
    output u8u16_pkg::t_evt     o_head
);
    import u8u16_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_evt            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_space      = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && o_space;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("fifo count overrun");

    property p_full_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!o_space && !i_pop) |=> !o_space;
    endproperty
    a_full_hold: assert property (p_full_hold) else $error("full fifo lost an entry");

    property p_ptr_sync;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_count == '0) |-> (r_wr == r_rd);
    endproperty
    a_ptr_sync: assert property (p_ptr_sync) else $error("empty fifo pointers differ");

endmodule

`default_nettype wire

>>> rtl/u8u16_back.sv
`default_nettype none

module u8u16_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_head_valid,
    input  u8u16_pkg::t_evt     i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output u8u16_pkg::t_out_word o_out
);
    import u8u16_pkg::*;

    logic        r_phase;
    logic        r_valid;
    t_out_word   r_out, n_out;
    logic        load;
    logic        is_supp;
    logic [20:0] v;
    logic        n_phase;

    assign load    = (!r_valid || i_ready) && i_head_valid;
    assign is_supp = (i_head.code_point >= CP_SUPP_BASE) && !i_head.marker;
    assign v       = i_head.code_point - CP_SUPP_BASE;

    always_comb begin
        n_out   = r_out;
        n_phase = r_phase;
        o_pop   = 1'b0;
        if (load) begin
            if (i_head.marker) begin
                n_out = '{utf16_unit: 16'd0, unit_valid: 1'b0,
                          string_end: 1'b1, run_last: 1'b1};
                o_pop = 1'b1;
            end else if (!is_supp) begin
                n_out = '{utf16_unit: i_head.code_point[15:0], unit_valid: 1'b1,
                          string_end: i_head.str_end, run_last: 1'b1};
                o_pop = 1'b1;
            end else if (!r_phase) begin
                n_out   = '{utf16_unit: UNIT_HI_BASE + {5'd0, v[20:10]}, unit_valid: 1'b1,
                            string_end: 1'b0, run_last: 1'b0};
                n_phase = 1'b1;
            end else begin
                n_out   = '{utf16_unit: UNIT_LO_BASE | {6'd0, v[9:0]}, unit_valid: 1'b1,
                            string_end: i_head.str_end, run_last: 1'b1};
                n_phase = 1'b0;
                o_pop   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    property p_phase_head;
        @(posedge i_clk) disable iff (!i_rst_n) r_phase |-> (i_head_valid && is_supp);
    endproperty
    a_phase_head: assert property (p_phase_head) else $error("low half without pending pair");

    property p_marker_form;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && !r_out.unit_valid) |-> (r_out.string_end && r_out.run_last);
    endproperty
    a_marker_form: assert property (p_marker_form) else $error("bad end marker");

    property p_end_is_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && r_out.string_end) |-> r_out.run_last;
    endproperty
    a_end_is_last: assert property (p_end_is_last) else $error("string end before run end");

    property p_hi_then_lo;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && !r_out.run_last) |-> r_phase;
    endproperty
    a_hi_then_lo: assert property (p_hi_then_lo) else $error("high surrogate not followed");

endmodule

`default_nettype wire

>>> rtl/utf8_to_utf16_decoder_top.sv
`default_nettype none
// Channel  Valid    Ready    Word
// input    i_valid  o_ready  i_in  (byte_value, last_byte)
// output   o_valid  i_ready  o_out (utf16_unit, unit_valid, string_end, run_last)
//
// One byte accepted per cycle while the event queue has room.
// A byte that completes a code point is written into the event queue, then loaded into the output register;
// a supplementary code point yields two output words (high, then low surrogate).
// Synchronous active-low reset clears decode state, queue and output valid.
// Output stalls back up through a QUEUE_DEPTH-entry queue before o_ready drops.

module utf8_to_utf16_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  u8u16_pkg::t_in_word    i_in,
    output logic                   o_valid,
    input  wire                    i_ready,
    output u8u16_pkg::t_out_word   o_out
);
    import u8u16_pkg::*;

    logic  push, pop, space, head_valid;
    t_evt  evt, head;

    u8u16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_space (space),
        .i_in    (i_in),
        .o_ready (o_ready),
        .o_push  (push),
        .o_evt   (evt)
    );

    u8u16_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_evt        (evt),
        .i_pop        (pop),
        .o_space      (space),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

import u8u16_pkg::*;

class t_unit_ledger;
    t_out_word   units_due[$];
    logic [20:0] code_accum;
    logic [1:0]  bytes_left;
    logic        seq_bad;
    int          n_bytes;
    int          n_strings;
    int          n_checked;
    int          n_pairs;
    int          n_replaced;
    int          n_markers;
    int          n_errors;

    function new();
        code_accum = '0;
        bytes_left = '0;
        seq_bad    = 1'b0;
        n_bytes    = 0;
        n_strings  = 0;
        n_checked  = 0;
        n_pairs    = 0;
        n_replaced = 0;
        n_markers  = 0;
        n_errors   = 0;
    endfunction

    function t_out_word make_word(logic [15:0] unit, logic valid, logic fin, logic last);
        t_out_word w;
        w.utf16_unit = unit;
        w.unit_valid = valid;
        w.string_end = fin;
        w.run_last   = last;
        return w;
    endfunction

    function void expect_word(t_out_word w);
        units_due.insert(units_due.size(), w);
    endfunction

    function void push_code_point(logic [20:0] cp, logic fin);
        logic [20:0] v;
        if (cp == CP_REPLACEMENT) n_replaced++;
        if (cp >= CP_SUPP_BASE) begin
            v = cp - CP_SUPP_BASE;
            expect_word(make_word(UNIT_HI_BASE + {5'd0, v[20:10]}, 1'b1, 1'b0, 1'b0));
            expect_word(make_word(UNIT_LO_BASE + {6'd0, v[9:0]}, 1'b1, fin, 1'b1));
            n_pairs++;
        end else begin
            expect_word(make_word(cp[15:0], 1'b1, fin, 1'b1));
        end
    endfunction

    function void take_byte(t_in_word w);
        logic [7:0]  b;
        logic [20:0] cp;
        logic        have_cp;
        b       = w.byte_value;
        cp      = '0;
        have_cp = 1'b0;
        n_bytes++;
        if (bytes_left == 2'd0) begin
            if (b[7] == 1'b0) begin
                cp      = {13'd0, b};
                have_cp = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                code_accum = {16'd0, b[4:0]};
                bytes_left = 2'd1;
                seq_bad    = 1'b0;
            end else if (b[7:4] == 4'b1110) begin
                code_accum = {17'd0, b[3:0]};
                bytes_left = 2'd2;
                seq_bad    = 1'b0;
            end else if (b[7:3] == 5'b11110) begin
                code_accum = {18'd0, b[2:0]};
                bytes_left = 2'd3;
                seq_bad    = 1'b0;
            end else begin
                cp      = CP_REPLACEMENT;
                have_cp = 1'b1;
            end
        end else begin
            if (!seq_bad) begin
                if (b[7:6] != 2'b10) seq_bad = 1'b1;
                else code_accum = {code_accum[14:0], b[5:0]};
            end
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0) begin
                cp         = seq_bad ? CP_REPLACEMENT : code_accum;
                have_cp    = 1'b1;
                seq_bad    = 1'b0;
                code_accum = '0;
            end
        end
        if (have_cp) begin
            push_code_point(cp, w.last_byte);
        end else if (w.last_byte) begin
            expect_word(make_word(16'h0000, 1'b0, 1'b1, 1'b1));
            n_markers++;
        end
        if (w.last_byte) begin
            code_accum = '0;
            bytes_left = '0;
            seq_bad    = 1'b0;
            n_strings++;
        end
    endfunction

    function void note_error(string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void match_unit(t_out_word got);
        t_out_word want;
        n_checked++;
        if (units_due.size() == 0) begin
            note_error($sformatf("word %0d unexpected: unit=%h valid=%b end=%b last=%b",
                n_checked, got.utf16_unit, got.unit_valid, got.string_end, got.run_last));
            return;
        end
        want = units_due.pop_front();
        if (got.utf16_unit !== want.utf16_unit || got.unit_valid !== want.unit_valid ||
            got.string_end !== want.string_end || got.run_last !== want.run_last) begin
            note_error($sformatf({"word %0d: expected unit=%h valid=%b end=%b last=%b, ",
                "got unit=%h valid=%b end=%b last=%b"}, n_checked,
                want.utf16_unit, want.unit_valid, want.string_end, want.run_last,
                got.utf16_unit, got.unit_valid, got.string_end, got.run_last));
        end
    endfunction
endclass

module tb;
    localparam int LONG_STALL     = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_BYTES   = 750;

    typedef enum int {
        SEQ_ASCII, SEQ_TWO, SEQ_THREE, SEQ_FOUR, SEQ_STRAY, SEQ_BADCONT, SEQ_NOISE
    } t_seq_kind;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_in;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_out;

    t_unit_ledger ledger = new();
    logic [7:0] str_bytes[$];
    int         seq_len;
    int         burst_left = 0;
    int         n_sent = 0;
    int         idle_cycles = 0;
    logic       stall_request = 1'b0;

    utf8_to_utf16_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) ledger.take_byte(i_in);
            if (o_valid && i_ready) ledger.match_unit(o_out);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("timeout: no word moved for %0d cycles, %0d units pending",
                        idle_cycles, ledger.units_due.size());
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // receiver: random stall pattern, plus one long hold on request
    initial begin
        int       tick;
        t_rx_mode mode;
        tick = 0;
        mode = RX_FREE;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else begin
                if (tick % 48 == 0) mode = t_rx_mode'($urandom_range(0, 3));
                tick++;
                case (mode)
                    RX_FREE:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= (tick % 4 == 0);
                    default:   i_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic put_byte(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_in    <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_string();
        t_in_word w;
        for (int k = 0; k < str_bytes.size(); k++) begin
            w.byte_value = str_bytes[k];
            w.last_byte  = (k == str_bytes.size() - 1);
            put_byte(w);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (ledger.units_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    function automatic t_seq_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return SEQ_ASCII;
        if (r < 45) return SEQ_TWO;
        if (r < 65) return SEQ_THREE;
        if (r < 85) return SEQ_FOUR;
        if (r < 90) return SEQ_STRAY;
        if (r < 96) return SEQ_BADCONT;
        return SEQ_NOISE;
    endfunction

    task automatic add_seq(input t_seq_kind kind);
        logic [20:0] cp;
        logic [7:0]  b;
        int          n;
        int          bad_at;
        cp = 21'($urandom);
        case (kind)
            SEQ_ASCII: begin
                add_byte({1'b0, cp[6:0]});
                seq_len = 1;
            end
            SEQ_TWO: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
                seq_len = 2;
            end
            SEQ_THREE: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
                seq_len = 3;
            end
            SEQ_FOUR: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
                seq_len = 4;
            end
            SEQ_STRAY: begin
                if (cp[0]) add_byte({2'b10, cp[6:1]});
                else add_byte({5'b11111, cp[3:1]});
                seq_len = 1;
            end
            SEQ_BADCONT: begin
                n = $urandom_range(1, 3);
                case (n)
                    1:       add_byte({3'b110, cp[4:0]});
                    2:       add_byte({4'b1110, cp[3:0]});
                    default: add_byte({5'b11110, cp[2:0]});
                endcase
                bad_at = $urandom_range(0, n - 1);
                for (int k = 0; k < n; k++) begin
                    b = 8'($urandom);
                    if (k < bad_at) b = {2'b10, b[5:0]};
                    else if (k == bad_at && b[7:6] == 2'b10) b[6] = 1'b1;
                    add_byte(b);
                end
                seq_len = n + 1;
            end
            default: begin
                add_byte(cp[7:0]);
                seq_len = 1;
            end
        endcase
    endtask

    task automatic send_random_string();
        int n_seq;
        n_seq = $urandom_range(1, 8);
        str_bytes.delete();
        repeat (n_seq) add_seq(pick_kind());
        // cut the final sequence short now and then
        if ($urandom_range(0, 7) == 0 && seq_len > 1)
            repeat ($urandom_range(1, seq_len - 1)) void'(str_bytes.pop_back());
        send_string();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ascii, 2/3/4-byte forms, stray continuation, bad leads, bad continuation,
        // value above the code space, lead byte as final byte
        str_bytes = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                      8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hF8,
                      8'hE2, 8'h41, 8'hC0, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC3};
        send_string();
        // truncated sequence, then a one-byte string
        str_bytes = '{8'hE2, 8'h82};
        send_string();
        str_bytes = '{8'h41};
        send_string();

        while (n_sent < TARGET_BYTES / 2) send_random_string();

        wait_drained();

        // long receiver hold while input keeps coming
        stall_request = 1'b1;
        str_bytes.delete();
        repeat (40) add_byte({1'b0, 7'($urandom)});
        send_string();

        while (n_sent < TARGET_BYTES) send_random_string();

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d bytes in %0d strings; %0d words checked",
            ledger.n_bytes, ledger.n_strings, ledger.n_checked);
        $display("%0d surrogate pairs, %0d replacement units, %0d bare end markers",
            ledger.n_pairs, ledger.n_replaced, ledger.n_markers);
        if (ledger.units_due.size() != 0)
            ledger.note_error($sformatf("%0d words never arrived", ledger.units_due.size()));
        if (ledger.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
